### src/gcmn_pkg.sv
// shared types and constants for the grid clearance map block
package gcmn_pkg;

  // item kinds carried in tuser
  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_REBUILD = 2'd1;
  localparam logic [1:0] KIND_QUERY   = 2'd2;
  localparam logic [1:0] KIND_SPARE   = 2'd3;  // unused kind, zero result

  // register indexes of the configuration port
  localparam logic REG_GRID_COLS = 1'b0;
  localparam logic REG_GRID_ROWS = 1'b1;

  localparam int unsigned CLR_W   = 7;  // clearance and grid size width
  localparam int unsigned COORD_W = 6;  // cell coordinate width on the port
  localparam int unsigned XW      = 9;  // internal coordinate width, wraps below zero

  typedef struct packed {
    logic [CLR_W-1:0] cols;
    logic [CLR_W-1:0] rows;
  } grid_cfg_t;

endpackage

### src/grid_clearance_map_neighbors.sv
// top level: grid walkable map, clearance rebuild and neighbor query
//
// Input transactions arrive on s_axis (tuser = kind, tdata = cell and data).
// A write stores one walkable bit, a rebuild recomputes every clearance, a
// query returns the cell clearance and a mask of passable neighbors on
// m_axis. Every input transaction yields exactly one output transaction.
// The grid size is to be set by the user through the cfg write port only
// while the block is idle; the block itself does not enforce this. One item
// is in work at a time; the walkable map and the clearance map each sit in a
// ram with one write and one registered read port. A query pipelines five
// reads through the read port; a rebuild handles each cell in a read state
// and then a write state of the clearance ram.
// After reset a clearing pass over all MAX_COLS * MAX_ROWS cells sets them
// walkable with clearance zero; s_axis_tready stays low meanwhile.
// The result sits in an output register, so a new item is accepted while
// the receiver stalls; the block waits only when a second result is ready
// before the first one is taken.
module grid_clearance_map_neighbors #(
  parameter int unsigned MAX_COLS = 64,
  parameter int unsigned MAX_ROWS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [23:0]                  s_axis_tdata,  // cell_col, cell_row, walkable_bit,
                                                      // need_clearance, zero fill
  input  logic [1:0]                   s_axis_tuser,  // kind
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [15:0]                  m_axis_tdata,  // neighbor_mask, cell_clearance,
                                                      // zero fill
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [gcmn_pkg::CLR_W-1:0]   cfg_data_i
);
  import gcmn_pkg::*;

  localparam int unsigned DEPTH = MAX_COLS * MAX_ROWS;
  localparam int unsigned AW    = $clog2(DEPTH);

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_QRY   = 3'd2;
  localparam logic [2:0] ST_RB_RD = 3'd3;
  localparam logic [2:0] ST_RB_WR = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] c, input logic [XW-1:0] r);
    return AW'(32'(c) * MAX_ROWS + 32'(r));
  endfunction

  grid_cfg_t cfg;

  gcmn_cfg #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cfg_o(cfg)
  );

  // input fields
  logic [COORD_W-1:0] in_col, in_row;
  logic               in_walk;
  logic [CLR_W-1:0]   in_need;
  assign in_col  = s_axis_tdata[5:0];
  assign in_row  = s_axis_tdata[11:6];
  assign in_walk = s_axis_tdata[12];
  assign in_need = s_axis_tdata[19:13];

  logic [2:0]       state_q;
  logic [AW-1:0]    clr_cnt_q;
  logic [XW-1:0]    q_col_q, q_row_q;
  logic [CLR_W-1:0] need_q;
  logic [2:0]       qk_q, rd_idx_q;
  logic             rd_vld_q, rd_in_q;
  logic [3:0]       res_mask_q;
  logic [CLR_W-1:0] res_clr_q;
  logic [XW-1:0]    rb_c_q, rb_r_q;
  logic [CLR_W-1:0] s_below_q, s_diag_q;
  logic             rb_rin_q;
  logic             out_valid_q;
  logic [3:0]       out_mask_q;
  logic [CLR_W-1:0] out_clr_q;

  // memory ports
  logic             walk_we, walk_wdata, walk_rdata;
  logic [AW-1:0]    walk_waddr, walk_raddr;
  logic             clr_we;
  logic [CLR_W-1:0] clr_wdata, clr_rdata;
  logic [AW-1:0]    clr_waddr, clr_raddr;

  gcmn_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_walk_ram (
    .clk_i, .we_i(walk_we), .waddr_i(walk_waddr), .wdata_i(walk_wdata),
    .raddr_i(walk_raddr), .rdata_o(walk_rdata)
  );

  gcmn_ram #(.WIDTH(CLR_W), .DEPTH(DEPTH)) u_clr_ram (
    .clk_i, .we_i(clr_we), .waddr_i(clr_waddr), .wdata_i(clr_wdata),
    .raddr_i(clr_raddr), .rdata_o(clr_rdata)
  );

  logic in_acc, in_inside;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_inside     = (CLR_W'(in_col) < cfg.cols) && (CLR_W'(in_row) < cfg.rows);

  // query cell for the current read slot: center, above, right, below, left
  logic [XW-1:0] qc, qr;
  logic          q_in;
  always_comb begin
    qc = q_col_q;
    qr = q_row_q;
    case (qk_q)
      3'd1:    qr = q_row_q + XW'(1);
      3'd2:    qc = q_col_q + XW'(1);
      3'd3:    qr = q_row_q - XW'(1);
      3'd4:    qc = q_col_q - XW'(1);
      default: ;
    endcase
    q_in = (qc < XW'(cfg.cols)) && (qr < XW'(cfg.rows));
  end

  // rebuild: square size from right, below and diagonal neighbors
  logic [CLR_W-1:0] s_right, s_min, s_new;
  always_comb begin
    s_right = rb_rin_q ? clr_rdata : '0;
    s_min   = (s_right < s_below_q) ? s_right : s_below_q;
    if (s_diag_q < s_min) s_min = s_diag_q;
    s_new   = walk_rdata ? s_min + CLR_W'(1) : '0;
  end

  // memory port selection
  always_comb begin
    walk_we    = 1'b0;
    walk_waddr = clr_cnt_q;
    walk_wdata = 1'b1;
    clr_we     = 1'b0;
    clr_waddr  = clr_cnt_q;
    clr_wdata  = '0;
    walk_raddr = cell_addr(qc, qr);
    clr_raddr  = cell_addr(qc, qr);
    case (state_q)
      ST_CLR: begin
        walk_we = 1'b1;
        clr_we  = 1'b1;
      end
      ST_IDLE: begin
        walk_we    = in_acc && (s_axis_tuser == KIND_WRITE) && in_inside;
        walk_waddr = cell_addr(XW'(in_col), XW'(in_row));
        walk_wdata = in_walk;
      end
      ST_RB_RD: begin
        walk_raddr = cell_addr(rb_c_q, rb_r_q);
        clr_raddr  = cell_addr(rb_c_q + XW'(1), rb_r_q);
      end
      ST_RB_WR: begin
        clr_we    = 1'b1;
        clr_waddr = cell_addr(rb_c_q, rb_r_q);
        clr_wdata = s_new;
      end
      default: ;
    endcase
  end

  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready;

  // control sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_cnt_q   <= '0;
      q_col_q     <= '0;
      q_row_q     <= '0;
      need_q      <= '0;
      qk_q        <= '0;
      rd_idx_q    <= '0;
      rd_vld_q    <= 1'b0;
      rd_in_q     <= 1'b0;
      res_mask_q  <= '0;
      res_clr_q   <= '0;
      rb_c_q      <= '0;
      rb_r_q      <= '0;
      s_below_q   <= '0;
      s_diag_q    <= '0;
      rb_rin_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_mask_q  <= '0;
      out_clr_q   <= '0;
    end else begin
      if (out_valid_q && m_axis_tready && (state_q != ST_DONE)) out_valid_q <= 1'b0;
      case (state_q)
        ST_CLR: begin
          clr_cnt_q <= clr_cnt_q + AW'(1);
          if (clr_cnt_q == AW'(DEPTH - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_acc) begin
            res_mask_q <= '0;
            res_clr_q  <= '0;
            q_col_q    <= XW'(in_col);
            q_row_q    <= XW'(in_row);
            need_q     <= in_need;
            qk_q       <= '0;
            rd_vld_q   <= 1'b0;
            rb_c_q     <= XW'(cfg.cols) - XW'(1);
            rb_r_q     <= '0;
            s_below_q  <= '0;
            s_diag_q   <= '0;
            state_q    <= ST_DONE;
            if (s_axis_tuser == KIND_REBUILD) state_q <= ST_RB_RD;
            if (s_axis_tuser == KIND_QUERY && in_inside) state_q <= ST_QRY;
          end
        end
        ST_QRY: begin
          rd_vld_q <= (qk_q <= 3'd4);
          rd_idx_q <= qk_q;
          rd_in_q  <= q_in;
          if (qk_q <= 3'd4) qk_q <= qk_q + 3'd1;
          if (rd_vld_q) begin
            if (rd_idx_q == 3'd0) begin
              res_clr_q <= clr_rdata;
            end else begin
              res_mask_q[2'(rd_idx_q - 3'd1)] <= rd_in_q && walk_rdata && (clr_rdata >= need_q);
            end
            if (rd_idx_q == 3'd4) state_q <= ST_DONE;
          end
        end
        ST_RB_RD: begin
          rb_rin_q <= (rb_c_q + XW'(1)) < XW'(cfg.cols);
          state_q  <= ST_RB_WR;
        end
        ST_RB_WR: begin
          state_q <= ST_RB_RD;
          if (rb_r_q == XW'(cfg.rows) - XW'(1)) begin
            rb_r_q    <= '0;
            s_below_q <= '0;
            s_diag_q  <= '0;
            rb_c_q    <= rb_c_q - XW'(1);
            if (rb_c_q == '0) state_q <= ST_DONE;
          end else begin
            rb_r_q    <= rb_r_q + XW'(1);
            s_below_q <= s_new;
            s_diag_q  <= s_right;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_mask_q  <= res_mask_q;
            out_clr_q   <= res_clr_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_clr_q, out_mask_q};

  logic [CLR_W-1:0] grid_min;
  assign grid_min = (cfg.cols < cfg.rows) ? cfg.cols : cfg.rows;

`ifndef NO_ASSERTIONS
  // a rebuilt clearance never exceeds the smaller grid side
  a_rb_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RB_WR) |-> (clr_wdata <= grid_min))
    else $error("rebuild clearance above grid bound");

  // a new result only comes from the done state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("output loaded outside done state");

  // a loaded result never overwrites one that was not taken
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_q && !m_axis_tready) |=> (state_q == ST_DONE))
    else $error("result dropped while receiver stalls");

  // no write transaction reaches the walk ram during the clearing pass
  a_clr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR) |-> (!s_axis_tready && walk_wdata))
    else $error("input taken during clearing pass");
`endif

endmodule

### src/gcmn_ram.sv
// generic single write, single read ram with registered read data
module gcmn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### src/gcmn_cfg.sv
// grid size registers with range clamping
module gcmn_cfg #(
  parameter int unsigned MAX_COLS = 64,
  parameter int unsigned MAX_ROWS = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [gcmn_pkg::CLR_W-1:0]      cfg_data_i,
  output gcmn_pkg::grid_cfg_t             cfg_o
);
  import gcmn_pkg::*;

  localparam logic [8:0] MaxColsW = 9'(MAX_COLS);
  localparam logic [8:0] MaxRowsW = 9'(MAX_ROWS);
  localparam logic [8:0] ResetW   = 9'd64;
  localparam logic [CLR_W-1:0] ColsRst = (ResetW > MaxColsW) ? CLR_W'(MAX_COLS) : CLR_W'(64);
  localparam logic [CLR_W-1:0] RowsRst = (ResetW > MaxRowsW) ? CLR_W'(MAX_ROWS) : CLR_W'(64);

  logic [CLR_W-1:0] cols_q, cols_d, rows_q, rows_d;
  logic [CLR_W-1:0] cols_clamp, rows_clamp;

  // zero reads as one, anything above the maximum as the maximum
  always_comb begin
    cols_clamp = cfg_data_i;
    rows_clamp = cfg_data_i;
    if (cfg_data_i == '0) begin
      cols_clamp = CLR_W'(1);
      rows_clamp = CLR_W'(1);
    end
    if (9'(cfg_data_i) > MaxColsW) cols_clamp = MaxColsW[CLR_W-1:0];
    if (9'(cfg_data_i) > MaxRowsW) rows_clamp = MaxRowsW[CLR_W-1:0];
  end

  always_comb begin
    cols_d = cols_q;
    rows_d = rows_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GRID_COLS: cols_d = cols_clamp;
        REG_GRID_ROWS: rows_d = rows_clamp;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= ColsRst;
      rows_q <= RowsRst;
    end else begin
      cols_q <= cols_d;
      rows_q <= rows_d;
    end
  end

  assign cfg_o.cols = cols_q;
  assign cfg_o.rows = rows_q;

endmodule

### test/grid_clearance_map_neighbors_tb.sv
// self-checking testbench for the grid clearance map with neighbor query
`timescale 1ns / 1ps

module grid_clearance_map_neighbors_tb;
  import gcmn_pkg::*;

  localparam int unsigned NCOLS = 64;
  localparam int unsigned NROWS = 64;
  localparam int unsigned IDLE_LIMIT = 40000;

  typedef struct packed {
    logic [3:0]       mask;
    logic [CLR_W-1:0] clr;
  } nbr_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [23:0]        s_axis_tdata = '0;
  logic [1:0]         s_axis_tuser = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [15:0]        m_axis_tdata;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = 1'b0;
  logic [CLR_W-1:0]   cfg_data_i = '0;

  // predictor state
  bit                 walk_q [NCOLS*NROWS];
  logic [CLR_W-1:0]   clr_q  [NCOLS*NROWS];
  int                 cols_q, rows_q;
  nbr_result_t        pending_results [$];
  int                 mismatches = 0;
  int                 idle_cycles = 0;
  bit                 busy_free = 1'b0;  // long stretch with no idling
  bit                 rx_calm = 1'b0;

  grid_clearance_map_neighbors dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic bit in_grid(int c, int r);
    return c >= 0 && r >= 0 && c < cols_q && r < rows_q;
  endfunction

  function automatic bit open_at(int c, int r);
    return in_grid(c, r) && walk_q[c*NROWS + r];
  endfunction

  function automatic int ring_depth(int c, int r);
    int m;
    m = (cols_q < rows_q) ? cols_q : rows_q;
    if (!open_at(c, r)) return 0;
    for (int i = 1; i < m; i++) begin
      for (int j = 0; j <= i; j++)
        if (!open_at(c + j, r - i)) return i;
      for (int j = 0; j <= i; j++)
        if (!open_at(c + i, r - j)) return i;
    end
    return m;
  endfunction

  function automatic bit enterable(int c, int r, int need);
    return open_at(c, r) && int'(clr_q[c*NROWS + r]) >= need;
  endfunction

  function automatic nbr_result_t predict_grid(logic [1:0] kind, int c, int r, bit w, int need);
    nbr_result_t res;
    res = '0;
    case (kind)
      KIND_WRITE: begin
        if (in_grid(c, r)) walk_q[c*NROWS + r] = w;
      end
      KIND_REBUILD: begin
        for (int cc = 0; cc < cols_q; cc++)
          for (int rr = 0; rr < rows_q; rr++)
            clr_q[cc*NROWS + rr] = CLR_W'(ring_depth(cc, rr));
      end
      KIND_QUERY: begin
        if (in_grid(c, r)) begin
          res.clr = clr_q[c*NROWS + r];
          res.mask[0] = enterable(c, r + 1, need);
          res.mask[1] = enterable(c + 1, r, need);
          res.mask[2] = enterable(c, r - 1, need);
          res.mask[3] = enterable(c - 1, r, need);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // send one item and record its expected result
  task automatic send_item(logic [1:0] kind, int c, int r, bit w, int need);
    nbr_result_t exp_res;
    while (!busy_free && $urandom_range(99) < 26) @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = kind;
    s_axis_tdata  = {4'b0, 7'(need), w, 6'(r), 6'(c)};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    exp_res = predict_grid(kind, c, r, w, need);
    pending_results = {pending_results, exp_res};
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic set_grid(int cols, int rows, int raw_cols = -1, int raw_rows = -1);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_GRID_COLS;
    cfg_data_i <= CLR_W'(raw_cols < 0 ? cols : raw_cols);
    @(negedge clk_i);
    cfg_idx_i  <= REG_GRID_ROWS;
    cfg_data_i <= CLR_W'(raw_rows < 0 ? rows : raw_rows);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    cols_q = cols;
    rows_q = rows;
  endtask

  task automatic test_directed();
    send_item(KIND_QUERY, 0, 0, 0, 0);
    send_item(KIND_REBUILD, 0, 0, 0, 0);
    send_item(KIND_QUERY, 63, 63, 1, 64);
    send_item(KIND_QUERY, 0, 0, 0, 1);
    send_item(KIND_WRITE, 10, 10, 0, 0);
    send_item(KIND_WRITE, 63, 0, 0, 127);
    send_item(KIND_REBUILD, 0, 0, 0, 0);
    send_item(KIND_QUERY, 10, 11, 0, 0);
    send_item(KIND_QUERY, 9, 10, 1, 3);
    send_item(KIND_QUERY, 62, 0, 1, 1);
    // unused kind gives a zero result
    send_item(KIND_SPARE, 5, 5, 1, 7);
    send_item(KIND_WRITE, 10, 10, 1, 0);
    // stale clearances are kept until a rebuild
    send_item(KIND_QUERY, 10, 10, 0, 0);
  endtask

  task automatic test_small_grids();
    // zero clamps to one, above maximum clamps to the maximum
    set_grid(1, 1, 0, 0);
    send_item(KIND_REBUILD, 0, 0, 0, 0);
    send_item(KIND_QUERY, 0, 0, 0, 0);
    send_item(KIND_QUERY, 1, 0, 0, 0);
    send_item(KIND_WRITE, 5, 5, 0, 0);
    set_grid(64, 64, 127, 100);
    send_item(KIND_QUERY, 5, 5, 0, 0);
    set_grid(1, 64);
    send_item(KIND_REBUILD, 0, 0, 0, 0);
    send_item(KIND_QUERY, 0, 30, 1, 1);
  endtask

  task automatic test_random(int n_items, int cols, int rows);
    int c, r, roll;
    set_grid(cols, rows);
    for (int k = 0; k < n_items; k++) begin
      roll = $urandom_range(99);
      c = (roll < 90) ? $urandom_range(cols - 1) : $urandom_range(63);
      r = (roll < 90) ? $urandom_range(rows - 1) : $urandom_range(63);
      if (k == n_items / 2) begin
        drain_results();
        busy_free = 1'b1;
        rx_calm = 1'b1;
      end
      if (k == n_items / 2 + 60) begin
        busy_free = 1'b0;
        rx_calm = 1'b0;
      end
      roll = $urandom_range(99);
      if (roll < 45)
        send_item(KIND_WRITE, c, r, $urandom_range(99) < 70, $urandom_range(127));
      else if (roll < 50)
        send_item(KIND_REBUILD, c, r, $urandom_range(1), $urandom_range(127));
      else if (roll < 97)
        send_item(KIND_QUERY, c, r, $urandom_range(1), $urandom_range(7));
      else
        send_item(KIND_SPARE, c, r, $urandom_range(1), $urandom_range(127));
    end
  endtask

  // result checker and receiver stall
  always @(posedge clk_i) begin
    nbr_result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[3:0] !== want.mask || m_axis_tdata[10:4] !== want.clr
            || m_axis_tdata[15:11] !== '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: mask exp %h got %h, clearance exp %0d got %0d",
                     want.mask, m_axis_tdata[3:0], want.clr, m_axis_tdata[10:4]);
        end
      end
    end
  end

  always @(negedge clk_i) m_axis_tready <= rx_calm || $urandom_range(99) >= 26;

  // watchdog on cycles with no transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("grid_clearance_map_neighbors_tb NOT OK");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    for (int i = 0; i < NCOLS*NROWS; i++) begin
      walk_q[i] = 1'b1;
      clr_q[i] = '0;
    end
    cols_q = 64;
    rows_q = 64;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_small_grids();
    test_random(300, 6, 5);
    test_random(300, 3, 9);
    test_random(300, 8, 8);
    test_random(150, 2, 1);
    test_random(60, 64, 64);
    drain_results();
    if (mismatches == 0 && pending_results.size() == 0)
      $display("grid_clearance_map_neighbors_tb OK");
    else
      $display("grid_clearance_map_neighbors_tb NOT OK");
    $finish;
  end

endmodule
